[rtl/cleb_pkg.sv]
// Package with the shared types, key codes and pointer helpers of the console line editor.
`default_nettype none

package cleb_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int PTR_MOD = 2 * BUFFER_DEPTH;
    localparam int PTR_W = $clog2(PTR_MOD);
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_DEL = 8'h7F;
    localparam logic [7:0] KEY_CR = 8'h0D;
    localparam logic [7:0] KEY_NL = 8'h0A;

    localparam logic KIND_KEY = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] ECHO_NONE = 2'd0;
    localparam logic [1:0] ECHO_CHAR = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    localparam logic [2:0] RD_DATA = 3'd0;
    localparam logic [2:0] RD_DATA_NL = 3'd1;
    localparam logic [2:0] RD_EOF_TAKEN = 3'd2;
    localparam logic [2:0] RD_EOF_KEPT = 3'd3;
    localparam logic [2:0] RD_EMPTY = 3'd4;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] key_code;
        logic       first_of_read;
    } item_t;

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_ready;
        logic       dump_request;
        logic [2:0] read_status;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic       en;
        addr_t      addr;
        logic [7:0] data;
    } store_wr_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(PTR_MOD - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        ptr_t r;
        if (p == '0)
            r = PTR_W'(PTR_MOD - 1);
        else
            r = p - PTR_W'(1);
        return r;
    endfunction

    function automatic ptr_t ptr_dist(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (a < b)
            t = t + (PTR_W + 1)'(PTR_MOD);
        return t[PTR_W-1:0];
    endfunction

    function automatic addr_t ptr_slot(input ptr_t p);
        ptr_t r;
        if (p >= PTR_W'(BUFFER_DEPTH))
            r = p - PTR_W'(BUFFER_DEPTH);
        else
            r = p;
        return r[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/cleb_store.sv]
// Line store memory with one write port and one registered read port with write bypass.
`default_nettype none

module cleb_store (
    input  wire logic                clk,
    input  wire cleb_pkg::store_wr_t wr,
    input  wire cleb_pkg::addr_t     rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] store_mem [cleb_pkg::BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            store_mem[wr.addr] <= wr.data;
        if (wr.en && (wr.addr == rd_addr))
            rd_data_reg <= wr.data;
        else
            rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/cleb_step.sv]
// Per-item editing logic: pointer updates, store write request and result fields.
`default_nettype none

module cleb_step (
    input  wire cleb_pkg::item_t     item,
    input  wire logic                item_vld,
    input  wire logic [7:0]          head_byte,
    input  wire cleb_pkg::ptr_t      read_ptr,
    input  wire cleb_pkg::ptr_t      commit_ptr,
    input  wire cleb_pkg::ptr_t      edit_ptr,
    output cleb_pkg::ptr_t           read_ptr_next,
    output cleb_pkg::ptr_t           commit_ptr_next,
    output cleb_pkg::ptr_t           edit_ptr_next,
    output cleb_pkg::store_wr_t      wr,
    output cleb_pkg::result_t        res
);

    logic [7:0]     key;
    logic [7:0]     ch;
    cleb_pkg::ptr_t uncommitted;
    cleb_pkg::ptr_t used;
    cleb_pkg::ptr_t edit_inc;

    assign key = item.key_code;
    assign ch = (key == cleb_pkg::KEY_CR) ? cleb_pkg::KEY_NL : key;
    assign uncommitted = cleb_pkg::ptr_dist(edit_ptr, commit_ptr);
    assign used = cleb_pkg::ptr_dist(edit_ptr, read_ptr);
    assign edit_inc = cleb_pkg::ptr_inc(edit_ptr);

    always_comb
    begin
        read_ptr_next = read_ptr;
        commit_ptr_next = commit_ptr;
        edit_ptr_next = edit_ptr;
        wr.en = 1'b0;
        wr.addr = cleb_pkg::ptr_slot(edit_ptr);
        wr.data = ch;
        res = '0;
        if (item_vld && (item.kind == cleb_pkg::KIND_KEY))
        begin
            priority if ((key == 8'd0) || key[7])
            begin
                res = '0;
            end
            else if (key == cleb_pkg::KEY_CTRL_P)
            begin
                res.dump_request = 1'b1;
            end
            else if (key == cleb_pkg::KEY_CTRL_U)
            begin
                if (uncommitted != '0)
                begin
                    edit_ptr_next = commit_ptr;
                    res.echo_kind = cleb_pkg::ECHO_ERASE;
                    if (32'(uncommitted) > 32'd255)
                        res.erase_count = 8'd255;
                    else
                        res.erase_count = 8'(uncommitted);
                end
            end
            else if ((key == cleb_pkg::KEY_CTRL_H) || (key == cleb_pkg::KEY_DEL))
            begin
                if (edit_ptr != commit_ptr)
                begin
                    edit_ptr_next = cleb_pkg::ptr_dec(edit_ptr);
                    res.echo_kind = cleb_pkg::ECHO_ERASE;
                    res.erase_count = 8'd1;
                end
            end
            else if (32'(used) < 32'(cleb_pkg::BUFFER_DEPTH))
            begin
                wr.en = 1'b1;
                edit_ptr_next = edit_inc;
                res.echo_kind = cleb_pkg::ECHO_CHAR;
                res.echo_char = ch;
                if ((ch == cleb_pkg::KEY_NL) || (ch == cleb_pkg::KEY_CTRL_D) ||
                    (32'(cleb_pkg::ptr_dist(edit_inc, read_ptr)) ==
                     32'(cleb_pkg::BUFFER_DEPTH)))
                begin
                    commit_ptr_next = edit_inc;
                    res.line_ready = 1'b1;
                end
            end
        end
        else if (item_vld)
        begin
            priority if (read_ptr == commit_ptr)
            begin
                res.read_status = cleb_pkg::RD_EMPTY;
            end
            else if (head_byte == cleb_pkg::KEY_CTRL_D)
            begin
                if (item.first_of_read)
                begin
                    read_ptr_next = cleb_pkg::ptr_inc(read_ptr);
                    res.read_status = cleb_pkg::RD_EOF_TAKEN;
                end
                else
                begin
                    res.read_status = cleb_pkg::RD_EOF_KEPT;
                end
            end
            else
            begin
                read_ptr_next = cleb_pkg::ptr_inc(read_ptr);
                res.read_status = (head_byte == cleb_pkg::KEY_NL) ?
                                  cleb_pkg::RD_DATA_NL : cleb_pkg::RD_DATA;
                res.read_data = head_byte;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/console_line_edit_buffer_core.sv]
// Top level of the console line editor: input register, editing logic, store and result register.
`default_nettype none

// The block takes one item per transfer: an item is accepted at a rising edge where
// start is high and busy is low. Busy is always low, so an item can be sent in every
// cycle. An item is either a keyboard key or a request to read one byte of a
// committed line.
// Each item produces exactly one result. The result is on the result port for one
// cycle with done high, from the edge after the accepting edge; results come out in
// item order. The receiver cannot stall; a result not taken in its cycle is gone.
// Throughput is one item per cycle. The loop that sets it is the pointer update
// together with the line store read: the store always presents the byte at the read
// pointer that the next item will see, with a bypass for a byte written just before.
// Reset clears the read, commit and edit pointers and the pipeline valid flags; the
// store contents are left undefined, which is safe since no byte is read before it is
// written.

module console_line_edit_buffer_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cleb_pkg::item_t   item,
    output logic                   done,
    output cleb_pkg::result_t      result
);

    cleb_pkg::item_t     item_reg;
    logic                item_vld_reg;
    cleb_pkg::ptr_t      read_ptr_reg;
    cleb_pkg::ptr_t      commit_ptr_reg;
    cleb_pkg::ptr_t      edit_ptr_reg;
    cleb_pkg::ptr_t      read_ptr_next;
    cleb_pkg::ptr_t      commit_ptr_next;
    cleb_pkg::ptr_t      edit_ptr_next;
    cleb_pkg::store_wr_t wr;
    cleb_pkg::result_t   res_next;
    cleb_pkg::result_t   result_reg;
    logic                done_reg;
    logic [7:0]          head_byte;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            done_reg <= 1'b0;
            read_ptr_reg <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg <= '0;
        end
        else
        begin
            item_vld_reg <= start && !busy;
            done_reg <= item_vld_reg;
            read_ptr_reg <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            edit_ptr_reg <= edit_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        if (item_vld_reg)
            result_reg <= res_next;
    end

    cleb_step u_step (
        .item            (item_reg),
        .item_vld        (item_vld_reg),
        .head_byte       (head_byte),
        .read_ptr        (read_ptr_reg),
        .commit_ptr      (commit_ptr_reg),
        .edit_ptr        (edit_ptr_reg),
        .read_ptr_next   (read_ptr_next),
        .commit_ptr_next (commit_ptr_next),
        .edit_ptr_next   (edit_ptr_next),
        .wr              (wr),
        .res             (res_next)
    );

    cleb_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (cleb_pkg::ptr_slot(read_ptr_next)),
        .rd_data (head_byte)
    );

    assign done = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/cleb_checker.sv]
// Port-level checker for the console line editor, bound to the top level.
`default_nettype none

module cleb_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire cleb_pkg::result_t result
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("An accepted item did not give a result two cycles later.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !done)
        else $error("A result appeared without an accepted item.");

    a_key_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.echo_kind != cleb_pkg::ECHO_NONE)) |->
        (result.read_status == cleb_pkg::RD_DATA) && (result.read_data == 8'd0))
        else $error("A key result carries read fields.");

    a_read_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.read_status != cleb_pkg::RD_DATA)) |->
        (result.echo_kind == cleb_pkg::ECHO_NONE) && !result.line_ready &&
        !result.dump_request)
        else $error("A read result carries key fields.");

    a_commit_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.line_ready) |-> (result.echo_kind == cleb_pkg::ECHO_CHAR))
        else $error("A line was committed without an echoed character.");

endmodule

bind console_line_edit_buffer_core cleb_checker u_cleb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
